// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the intersection unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cci_pkg.sv =====
// ----------------------------------------------------------------------------
// cci_pkg
// shared types and constants of the circle intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

    // width of the tolerance register
    localparam int TOL_WIDTH = 16;

    // digit width of the pipelined multipliers
    localparam int MUL_DIGIT = 17;

    // quotient bits produced by each divider, enough to spot the cap
    localparam int QUOT_BITS = 59;

    // magnitude cap of a rounded quotient
    localparam logic [QUOT_BITS-1:0] QUOT_CAP = QUOT_BITS'(1) << 56;

    // relation codes
    typedef enum logic [2:0] {
        REL_CONCENTRIC = 3'd0,
        REL_APART      = 3'd1,
        REL_CONTAINED  = 3'd2,
        REL_TOUCHING   = 3'd3,
        REL_CROSSING   = 3'd4
    } t_relation;

endpackage

`default_nettype wire

// ===== rtl/cci_if.sv =====
// ----------------------------------------------------------------------------
// cci interfaces
// valid/ready channels for circle pairs, results and the tolerance write
// ----------------------------------------------------------------------------
`default_nettype none

// circle pair channel
interface cci_in_if #(
    parameter int CW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] first_center_x;
    logic signed [CW-1:0] first_center_y;
    logic        [CW-2:0] first_radius;
    logic signed [CW-1:0] second_center_x;
    logic signed [CW-1:0] second_center_y;
    logic        [CW-2:0] second_radius;

    modport source (
        output valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_radius,
               second_center_x, second_center_y, second_radius,
        output ready
    );
endinterface

// result channel
interface cci_out_if #(
    parameter int CW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic        [1:0]    point_count;
    logic        [2:0]    relation;
    logic signed [CW-1:0] first_point_x;
    logic signed [CW-1:0] first_point_y;
    logic signed [CW-1:0] second_point_x;
    logic signed [CW-1:0] second_point_y;
    logic                 saturated;

    modport source (
        output valid, point_count, relation, first_point_x, first_point_y,
               second_point_x, second_point_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, point_count, relation, first_point_x, first_point_y,
               second_point_x, second_point_y, saturated,
        output ready
    );
endinterface

// tolerance write channel
interface cci_cfg_if import cci_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TOL_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cci_mul.sv =====
// ----------------------------------------------------------------------------
// cci_mul
// pipelined multiplier, one digit of the second operand per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cci_mul import cci_pkg::*; #(
    parameter int AW  = 8,
    parameter int BW  = 8,
    parameter int SDW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [AW-1:0]  i_a,
    input  wire logic [BW-1:0]  i_b,
    input  wire logic [SDW-1:0] i_side,
    output logic                o_valid,
    output logic [AW+BW-1:0]    o_p,
    output logic [SDW-1:0]      o_side
);

    localparam int NS  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BPW = NS * MUL_DIGIT;
    localparam int ACW = AW + BPW;
    localparam int PPW = AW + MUL_DIGIT;

    logic           r_valid [NS];
    logic [AW-1:0]  r_a     [NS];
    logic [BPW-1:0] r_b     [NS];
    logic [ACW-1:0] r_acc   [NS];
    logic [SDW-1:0] r_side  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           valid_in;
        logic [AW-1:0]  a_in;
        logic [BPW-1:0] b_in;
        logic [ACW-1:0] acc_in;
        logic [SDW-1:0] side_in;
        logic [PPW-1:0] pp;
        logic [ACW-1:0] n_acc;

        // stage inputs: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign valid_in = i_valid;
            assign a_in     = i_a;
            assign b_in     = BPW'(i_b);
            assign acc_in   = '0;
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[k-1];
            assign a_in     = r_a[k-1];
            assign b_in     = r_b[k-1];
            assign acc_in   = r_acc[k-1];
            assign side_in  = r_side[k-1];
        end

        // partial product of this digit, added at its weight
        assign pp    = PPW'(a_in) * PPW'(b_in[k*MUL_DIGIT +: MUL_DIGIT]);
        assign n_acc = acc_in + (ACW'(pp) << (k * MUL_DIGIT));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]    <= a_in;
                r_b[k]    <= b_in;
                r_acc[k]  <= n_acc;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_p     = r_acc[NS-1][AW+BW-1:0];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ===== rtl/cci_sqrt.sv =====
// ----------------------------------------------------------------------------
// cci_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cci_sqrt #(
    parameter int KW  = 8,
    parameter int SDW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [KW-1:0]  i_k,
    input  wire logic [SDW-1:0] i_side,
    output logic                o_valid,
    output logic [KW/2-1:0]     o_root,
    output logic [SDW-1:0]      o_side
);

    localparam int NS = KW / 2;

    logic           r_valid [NS];
    logic [KW-1:0]  r_num   [NS];
    logic [KW-1:0]  r_res   [NS];
    logic [SDW-1:0] r_side  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic           valid_in;
        logic [KW-1:0]  num_in;
        logic [KW-1:0]  res_in;
        logic [SDW-1:0] side_in;
        logic [KW-1:0]  bitv;
        logic [KW-1:0]  trial;
        logic [KW-1:0]  n_num;
        logic [KW-1:0]  n_res;

        if (k == 0) begin : g_first
            assign valid_in = i_valid;
            assign num_in   = i_k;
            assign res_in   = '0;
            assign side_in  = i_side;
        end else begin : g_next
            assign valid_in = r_valid[k-1];
            assign num_in   = r_num[k-1];
            assign res_in   = r_res[k-1];
            assign side_in  = r_side[k-1];
        end

        // trial subtract at this power of four
        assign bitv  = KW'(1) << (2 * (NS - 1 - k));
        assign trial = res_in + bitv;

        always_comb begin
            if (num_in >= trial) begin
                n_num = num_in - trial;
                n_res = (res_in >> 1) + bitv;
            end else begin
                n_num = num_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= n_num;
                r_res[k]  <= n_res;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_root  = r_res[NS-1][NS-1:0];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

// ===== rtl/cci_div.sv =====
// ----------------------------------------------------------------------------
// cci_div
// pipelined restoring divider giving floor((2n + d) / 2d), one bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div #(
    parameter int NW  = 8,
    parameter int DNW = 8,
    parameter int QB  = 8,
    parameter int SDW = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DNW-1:0] i_den,
    input  wire logic [SDW-1:0] i_side,
    output logic                o_valid,
    output logic [QB-1:0]       o_q,
    output logic [SDW-1:0]      o_side
);

    localparam int DW = DNW + 1;
    localparam int RW = ((NW > DNW + QB) ? NW : DNW + QB) + 2;

    // rounding prep: numerator 2n + d, divisor 2d
    logic           r_pvalid;
    logic [RW-1:0]  r_prem;
    logic [DW-1:0]  r_pd;
    logic [SDW-1:0] r_pside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (i_en) begin
            r_pvalid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prem  <= (RW'(i_num) << 1) + RW'(i_den);
            r_pd    <= {i_den, 1'b0};
            r_pside <= i_side;
        end
    end

    logic           r_valid [QB];
    logic [RW-1:0]  r_rem   [QB];
    logic [DW-1:0]  r_d     [QB];
    logic [QB-1:0]  r_q     [QB];
    logic [SDW-1:0] r_side  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic           valid_in;
        logic [RW-1:0]  rem_in;
        logic [DW-1:0]  d_in;
        logic [QB-1:0]  q_in;
        logic [SDW-1:0] side_in;
        logic [RW-1:0]  dsh;
        logic           ge;
        logic [RW-1:0]  n_rem;
        logic [QB-1:0]  n_q;

        if (k == 0) begin : g_first
            assign valid_in = r_pvalid;
            assign rem_in   = r_prem;
            assign d_in     = r_pd;
            assign q_in     = '0;
            assign side_in  = r_pside;
        end else begin : g_next
            assign valid_in = r_valid[k-1];
            assign rem_in   = r_rem[k-1];
            assign d_in     = r_d[k-1];
            assign q_in     = r_q[k-1];
            assign side_in  = r_side[k-1];
        end

        // compare and subtract at this quotient bit
        assign dsh   = RW'(d_in) << (QB - 1 - k);
        assign ge    = rem_in >= dsh;
        assign n_rem = ge ? rem_in - dsh : rem_in;
        assign n_q   = ge ? (q_in | (QB'(1) << (QB - 1 - k))) : q_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_d[k]    <= d_in;
                r_q[k]    <= n_q;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_q     = r_q[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

`default_nettype wire

// ===== rtl/circle_circle_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// circle_circle_intersection_unit
// classifies two circles and gives their touch or crossing points
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  i_pts    | in  | two centres, signed Q16.16, and radii, unsigned Q15.16
//  i_cfg    | in  | touch tolerance in LSBs
//  o_res    | out | relation, point count, two points, saturated flag
//
//  one beat accepted every cycle while the result is not stalled; the
//  pipeline's depth comes mostly from the bit-per-stage square root and
//  the bit-per-stage quotient dividers
//  synchronous active-low reset clears the valid bits, tolerance resets to 1
//  a stalled result holds the whole pipeline in place; nothing is dropped
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module circle_circle_intersection_unit import cci_pkg::*; #(
    parameter int CW = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cci_in_if.sink     i_pts,
    cci_cfg_if.sink    i_cfg,
    cci_out_if.source  o_res
);

    localparam int SW  = CW + 1;
    localparam int QW  = 2 * SW;
    localparam int NMW = QW + 1;
    localparam int PW  = NMW + 1;
    localparam int MPW = 2 * PW;
    localparam int FW  = CW + QUOT_BITS + 2;

    localparam logic signed [FW-1:0] C_MAX = FW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [FW-1:0] C_MIN = ~C_MAX;

    typedef struct packed {
        t_relation            rel;
        logic                 neg_x;
        logic                 neg_y;
        logic                 nneg;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic [SW-1:0]        ax;
        logic [SW-1:0]        ay;
        logic [NMW-1:0]       den;
    } t_ctx;

    typedef struct packed {
        t_ctx           c;
        logic [MPW-1:0] num_x;
        logic [MPW-1:0] num_y;
    } t_ctx_num;

    function automatic logic [QW-1:0] sq(input logic [SW-1:0] v);
        return QW'(v) * QW'(v);
    endfunction

    // capped rounded quotient with its sign
    function automatic logic signed [FW-1:0] smag(input logic [QUOT_BITS-1:0] q,
                                                  input logic neg);
        logic [QUOT_BITS-1:0] m;
        logic signed [FW-1:0] v;
        m = (q > QUOT_CAP) ? QUOT_CAP : q;
        v = FW'(m);
        return neg ? -v : v;
    endfunction

    // saturate to the coordinate range, flag in the top bit
    function automatic logic [CW:0] clip(input logic signed [FW-1:0] v);
        if (v > C_MAX) begin
            return {1'b1, C_MAX[CW-1:0]};
        end else if (v < C_MIN) begin
            return {1'b1, C_MIN[CW-1:0]};
        end
        return {1'b0, v[CW-1:0]};
    endfunction

    logic en;
    logic r_out_valid;

    // one enable moves every stage; held while the result waits
    assign en          = !r_out_valid || o_res.ready;
    assign i_pts.ready = en;
    assign i_cfg.ready = 1'b1;

    // tolerance register
    logic [TOL_WIDTH-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_WIDTH'(1);
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    // stage a: input capture
    logic                 r_a_valid;
    logic signed [CW-1:0] r_a_x1, r_a_y1, r_a_x2, r_a_y2;
    logic [CW-2:0]        r_a_r1, r_a_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_pts.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x1 <= i_pts.first_center_x;
            r_a_y1 <= i_pts.first_center_y;
            r_a_r1 <= i_pts.first_radius;
            r_a_x2 <= i_pts.second_center_x;
            r_a_y2 <= i_pts.second_center_y;
            r_a_r2 <= i_pts.second_radius;
        end
    end

    // stage b: differences, magnitudes and tolerance bounds
    logic [SW-1:0] n_dx, n_dy, n_s, n_diff, n_tol;
    logic          r_b_valid, r_b_negx, r_b_negy, r_b_tolbig;
    logic signed [CW-1:0] r_b_x1, r_b_y1;
    logic [SW-1:0] r_b_ax, r_b_ay, r_b_r1, r_b_r2, r_b_s, r_b_diff;
    logic [SW-1:0] r_b_tol, r_b_stol, r_b_dtol;

    assign n_dx   = {r_a_x2[CW-1], r_a_x2} - {r_a_x1[CW-1], r_a_x1};
    assign n_dy   = {r_a_y2[CW-1], r_a_y2} - {r_a_y1[CW-1], r_a_y1};
    assign n_s    = SW'(r_a_r1) + SW'(r_a_r2);
    assign n_diff = (r_a_r1 > r_a_r2) ? SW'(r_a_r1 - r_a_r2) : SW'(r_a_r2 - r_a_r1);
    assign n_tol  = SW'(r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_x1     <= r_a_x1;
            r_b_y1     <= r_a_y1;
            r_b_negx   <= n_dx[SW-1];
            r_b_negy   <= n_dy[SW-1];
            r_b_ax     <= n_dx[SW-1] ? -n_dx : n_dx;
            r_b_ay     <= n_dy[SW-1] ? -n_dy : n_dy;
            r_b_r1     <= SW'(r_a_r1);
            r_b_r2     <= SW'(r_a_r2);
            r_b_s      <= n_s;
            r_b_diff   <= n_diff;
            r_b_tol    <= n_tol;
            r_b_stol   <= n_s - n_tol;
            r_b_dtol   <= n_diff + n_tol;
            r_b_tolbig <= n_tol > n_s;
        end
    end

    // stage c: squares
    logic          r_c_valid, r_c_negx, r_c_negy, r_c_tolbig;
    logic signed [CW-1:0] r_c_x1, r_c_y1;
    logic [SW-1:0] r_c_ax, r_c_ay;
    logic [QW-1:0] r_c_ax2, r_c_ay2, r_c_tol2, r_c_s2, r_c_diff2;
    logic [QW-1:0] r_c_stol2, r_c_dtol2, r_c_r1sq, r_c_r2sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_x1     <= r_b_x1;
            r_c_y1     <= r_b_y1;
            r_c_negx   <= r_b_negx;
            r_c_negy   <= r_b_negy;
            r_c_tolbig <= r_b_tolbig;
            r_c_ax     <= r_b_ax;
            r_c_ay     <= r_b_ay;
            r_c_ax2    <= sq(r_b_ax);
            r_c_ay2    <= sq(r_b_ay);
            r_c_tol2   <= sq(r_b_tol);
            r_c_s2     <= sq(r_b_s);
            r_c_diff2  <= sq(r_b_diff);
            r_c_stol2  <= sq(r_b_stol);
            r_c_dtol2  <= sq(r_b_dtol);
            r_c_r1sq   <= sq(r_b_r1);
            r_c_r2sq   <= sq(r_b_r2);
        end
    end

    // stage d: squared centre distance
    logic          r_d_valid, r_d_negx, r_d_negy, r_d_tolbig;
    logic signed [CW-1:0] r_d_x1, r_d_y1;
    logic [SW-1:0] r_d_ax, r_d_ay;
    logic [QW-1:0] r_d_dist, r_d_tol2, r_d_s2, r_d_diff2;
    logic [QW-1:0] r_d_stol2, r_d_dtol2, r_d_r1sq, r_d_r2sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_x1     <= r_c_x1;
            r_d_y1     <= r_c_y1;
            r_d_negx   <= r_c_negx;
            r_d_negy   <= r_c_negy;
            r_d_tolbig <= r_c_tolbig;
            r_d_ax     <= r_c_ax;
            r_d_ay     <= r_c_ay;
            r_d_dist   <= r_c_ax2 + r_c_ay2;
            r_d_tol2   <= r_c_tol2;
            r_d_s2     <= r_c_s2;
            r_d_diff2  <= r_c_diff2;
            r_d_stol2  <= r_c_stol2;
            r_d_dtol2  <= r_c_dtol2;
            r_d_r1sq   <= r_c_r1sq;
            r_d_r2sq   <= r_c_r2sq;
        end
    end

    // stage e: classification and r1^2 + D
    t_relation     n_rel;
    logic          r_e_valid, r_e_negx, r_e_negy;
    logic signed [CW-1:0] r_e_x1, r_e_y1;
    logic [SW-1:0] r_e_ax, r_e_ay;
    t_relation     r_e_rel;
    logic [NMW-1:0] r_e_p;
    logic [QW-1:0] r_e_dist, r_e_r1sq, r_e_r2sq;

    always_comb begin
        priority if (r_d_dist == '0 || r_d_dist < r_d_tol2) begin
            n_rel = REL_CONCENTRIC;
        end else if (r_d_dist > r_d_s2) begin
            n_rel = REL_APART;
        end else if (r_d_dist < r_d_diff2) begin
            n_rel = REL_CONTAINED;
        end else if (r_d_tolbig || r_d_dist > r_d_stol2 || r_d_dist < r_d_dtol2) begin
            n_rel = REL_TOUCHING;
        end else begin
            n_rel = REL_CROSSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_x1   <= r_d_x1;
            r_e_y1   <= r_d_y1;
            r_e_negx <= r_d_negx;
            r_e_negy <= r_d_negy;
            r_e_ax   <= r_d_ax;
            r_e_ay   <= r_d_ay;
            r_e_rel  <= n_rel;
            r_e_p    <= NMW'(r_d_r1sq) + NMW'(r_d_dist);
            r_e_dist <= r_d_dist;
            r_e_r1sq <= r_d_r1sq;
            r_e_r2sq <= r_d_r2sq;
        end
    end

    // stage f: signed offset numerator |N| and its sign
    logic           n_nneg;
    logic           r_f_valid;
    t_ctx           r_f_ctx;
    logic [NMW-1:0] r_f_nm;
    logic [QW-1:0]  r_f_dist, r_f_r1sq;

    assign n_nneg = r_e_p < NMW'(r_e_r2sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_ctx.rel   <= r_e_rel;
            r_f_ctx.neg_x <= r_e_negx;
            r_f_ctx.neg_y <= r_e_negy;
            r_f_ctx.nneg  <= n_nneg;
            r_f_ctx.x1    <= r_e_x1;
            r_f_ctx.y1    <= r_e_y1;
            r_f_ctx.ax    <= r_e_ax;
            r_f_ctx.ay    <= r_e_ay;
            r_f_ctx.den   <= {r_e_dist, 1'b0};
            r_f_nm        <= n_nneg ? NMW'(r_e_r2sq) - r_e_p : r_e_p - NMW'(r_e_r2sq);
            r_f_dist      <= r_e_dist;
            r_f_r1sq      <= r_e_r1sq;
        end
    end

    // first multiplier bank: ax*N, ay*N, r1^2*D, N*N
    logic           m1_valid;
    t_ctx           m1_ctx;
    logic [MPW-1:0] m1_numx, m1_numy, m1_rd, m1_nsq;

    cci_mul #(.AW(PW), .BW(PW), .SDW($bits(t_ctx))) u_mul_nx (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_f_valid),
        .i_a(PW'(r_f_ctx.ax)), .i_b(PW'(r_f_nm)), .i_side(r_f_ctx),
        .o_valid(m1_valid), .o_p(m1_numx), .o_side(m1_ctx)
    );

    cci_mul #(.AW(PW), .BW(PW), .SDW(1)) u_mul_ny (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_f_valid),
        .i_a(PW'(r_f_ctx.ay)), .i_b(PW'(r_f_nm)), .i_side(1'b0),
        .o_valid(), .o_p(m1_numy), .o_side()
    );

    cci_mul #(.AW(PW), .BW(PW), .SDW(1)) u_mul_rd (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_f_valid),
        .i_a(PW'(r_f_r1sq)), .i_b(PW'(r_f_dist)), .i_side(1'b0),
        .o_valid(), .o_p(m1_rd), .o_side()
    );

    cci_mul #(.AW(PW), .BW(PW), .SDW(1)) u_mul_nn (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_f_valid),
        .i_a(PW'(r_f_nm)), .i_b(PW'(r_f_nm)), .i_side(1'b0),
        .o_valid(), .o_p(m1_nsq), .o_side()
    );

    // stage g: root operand 4*r1^2*D - N^2, floored at zero
    logic [MPW-1:0] n_k1;
    logic           r_g_valid;
    t_ctx_num       r_g_ctx;
    logic [MPW-1:0] r_g_k;

    assign n_k1 = m1_rd << 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_ctx.c     <= m1_ctx;
            r_g_ctx.num_x <= m1_numx;
            r_g_ctx.num_y <= m1_numy;
            r_g_k         <= (n_k1 > m1_nsq) ? n_k1 - m1_nsq : '0;
        end
    end

    // half chord numerator H
    logic          sq_valid;
    logic [PW-1:0] sq_root;
    t_ctx_num      sq_ctx;

    cci_sqrt #(.KW(MPW), .SDW($bits(t_ctx_num))) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_g_valid),
        .i_k(r_g_k), .i_side(r_g_ctx),
        .o_valid(sq_valid), .o_root(sq_root), .o_side(sq_ctx)
    );

    // second multiplier bank: ay*H, ax*H
    logic           m2_valid;
    t_ctx_num       m2_ctx;
    logic [MPW-1:0] m2_exn, m2_eyn;

    cci_mul #(.AW(PW), .BW(PW), .SDW($bits(t_ctx_num))) u_mul_ex (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sq_valid),
        .i_a(PW'(sq_ctx.c.ay)), .i_b(sq_root), .i_side(sq_ctx),
        .o_valid(m2_valid), .o_p(m2_exn), .o_side(m2_ctx)
    );

    cci_mul #(.AW(PW), .BW(PW), .SDW(1)) u_mul_ey (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sq_valid),
        .i_a(PW'(sq_ctx.c.ax)), .i_b(sq_root), .i_side(1'b0),
        .o_valid(), .o_p(m2_eyn), .o_side()
    );

    // divider bank, all over 2D
    logic                 dv_valid;
    t_ctx                 dv_ctx;
    logic [QUOT_BITS-1:0] dv_qx, dv_qy, dv_qex, dv_qey;

    cci_div #(.NW(MPW), .DNW(NMW), .QB(QUOT_BITS), .SDW($bits(t_ctx))) u_div_px (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m2_valid),
        .i_num(m2_ctx.num_x), .i_den(m2_ctx.c.den), .i_side(m2_ctx.c),
        .o_valid(dv_valid), .o_q(dv_qx), .o_side(dv_ctx)
    );

    cci_div #(.NW(MPW), .DNW(NMW), .QB(QUOT_BITS), .SDW(1)) u_div_py (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m2_valid),
        .i_num(m2_ctx.num_y), .i_den(m2_ctx.c.den), .i_side(1'b0),
        .o_valid(), .o_q(dv_qy), .o_side()
    );

    cci_div #(.NW(MPW), .DNW(NMW), .QB(QUOT_BITS), .SDW(1)) u_div_ex (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m2_valid),
        .i_num(m2_exn), .i_den(m2_ctx.c.den), .i_side(1'b0),
        .o_valid(), .o_q(dv_qex), .o_side()
    );

    cci_div #(.NW(MPW), .DNW(NMW), .QB(QUOT_BITS), .SDW(1)) u_div_ey (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(m2_valid),
        .i_num(m2_eyn), .i_den(m2_ctx.c.den), .i_side(1'b0),
        .o_valid(), .o_q(dv_qey), .o_side()
    );

    // stage h: base point p0 and signed chord offsets
    logic                 r_h_valid;
    t_relation            r_h_rel;
    logic signed [FW-1:0] r_h_p0x, r_h_p0y, r_h_ex, r_h_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_rel <= dv_ctx.rel;
            r_h_p0x <= FW'(dv_ctx.x1) + smag(dv_qx, dv_ctx.neg_x ^ dv_ctx.nneg);
            r_h_p0y <= FW'(dv_ctx.y1) + smag(dv_qy, dv_ctx.neg_y ^ dv_ctx.nneg);
            r_h_ex  <= smag(dv_qex, dv_ctx.neg_y);
            r_h_ey  <= smag(dv_qey, dv_ctx.neg_x);
        end
    end

    // stage i: point selection and saturation
    logic [1:0]    n_count;
    logic [CW:0]   n_fx, n_fy, n_sx, n_sy;
    logic          n_sat;

    always_comb begin
        n_count = 2'd0;
        n_fx    = '0;
        n_fy    = '0;
        n_sx    = '0;
        n_sy    = '0;
        unique case (r_h_rel)
            REL_TOUCHING: begin
                n_count = 2'd1;
                n_fx    = clip(r_h_p0x);
                n_fy    = clip(r_h_p0y);
            end
            REL_CROSSING: begin
                n_count = 2'd2;
                n_fx    = clip(r_h_p0x - r_h_ex);
                n_fy    = clip(r_h_p0y + r_h_ey);
                n_sx    = clip(r_h_p0x + r_h_ex);
                n_sy    = clip(r_h_p0y - r_h_ey);
            end
            default: begin
                n_count = 2'd0;
            end
        endcase
        n_sat = n_fx[CW] | n_fy[CW] | n_sx[CW] | n_sy[CW];
    end

    // output register
    logic [1:0]           r_out_count;
    logic [2:0]           r_out_rel;
    logic signed [CW-1:0] r_out_fx, r_out_fy, r_out_sx, r_out_sy;
    logic                 r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_count <= n_count;
            r_out_rel   <= r_h_rel;
            r_out_fx    <= n_fx[CW-1:0];
            r_out_fy    <= n_fy[CW-1:0];
            r_out_sx    <= n_sx[CW-1:0];
            r_out_sy    <= n_sy[CW-1:0];
            r_out_sat   <= n_sat;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.point_count    = r_out_count;
    assign o_res.relation       = r_out_rel;
    assign o_res.first_point_x  = r_out_fx;
    assign o_res.first_point_y  = r_out_fy;
    assign o_res.second_point_x = r_out_sx;
    assign o_res.second_point_y = r_out_sy;
    assign o_res.saturated      = r_out_sat;

    // checks
    `CCI_ASSERT_NEXT(a_stall_keeps_result, i_clk, i_rst_n, !i_pts.ready, r_out_valid, "stall lost a result")
    `CCI_ASSERT_NOW(a_two_iff_crossing, i_clk, i_rst_n, o_res.valid, (o_res.point_count == 2'd2) == (o_res.relation == REL_CROSSING), "point count and crossing disagree")
    `CCI_ASSERT_NOW(a_no_points_empty, i_clk, i_rst_n, o_res.valid && o_res.relation != REL_TOUCHING && o_res.relation != REL_CROSSING, o_res.point_count == 2'd0 && !o_res.saturated && o_res.first_point_x == '0 && o_res.second_point_y == '0, "points given without contact")
    `CCI_ASSERT_NOW(a_touch_one_point, i_clk, i_rst_n, o_res.valid && o_res.relation == REL_TOUCHING, o_res.point_count == 2'd1 && o_res.second_point_x == '0 && o_res.second_point_y == '0, "touch gave a second point")

endmodule

`default_nettype wire
